FILE: sv/lld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lld_pkg - shared types and widths for the line-to-line distance pipeline
// Widths of the exact intermediate values and the item carried by the
// bit-serial root chain.
// ----------------------------------------------------------------------------
package lld_pkg;

  localparam int COORD_W = 32;
  localparam int NUM_IN  = 12;
  localparam int IN_W    = NUM_IN * COORD_W;

  // numerator of the root ratio (square of the triple product, or |dp x d1|^2)
  localparam int REM_W  = 198;
  // denominator (|d1 x d2|^2 or |d1|^2)
  localparam int DEN_W  = 128;
  // running product root * denominator
  localparam int PROD_W = 160;
  localparam int ROOT_W = 32;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [PROD_W-1:0] prod;
    logic [ROOT_W-1:0] root;
    logic              par;
    logic              deg;
  } root_item_t;

endpackage

FILE: sv/line_line_distance_3d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_line_distance_3d - shortest distance between two 3D lines
// Exact-integer distance of two point/direction lines in signed fixed point.
// ----------------------------------------------------------------------------
// Each transfer on the input stream carries two lines, point and direction,
// every coordinate signed with FRAC_BITS fraction bits. One result leaves per
// query, in order. When |d1 x d2|^2 exceeds parallel_limit (units of 2^-32)
// the distance is |dp . (d1 x d2)| / |d1 x d2|, otherwise |dp x d1| / |d1|,
// with dp the second point minus the first. The distance is floored and
// saturates at all ones; a zero first direction in the parallel case gives
// distance 0 with degenerate set. A new query is taken every cycle unless the
// output stalls. 12 stages of vector arithmetic (products cut into 32-bit
// partial products) are followed by a 32-bit root chain that commits one
// result bit every two stages. Every stage holds independently, so bubbles
// close up while the output waits. Write parallel_limit only while idle.
// ----------------------------------------------------------------------------
module line_line_distance_3d
  import lld_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [31:0]     cfg_data,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // first_point_x/y/z, first_dir_x/y/z, second_point_x/y/z, second_dir_x/y/z,
  // 32 bits each, from the lowest bit up
  input  logic [IN_W-1:0] s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // distance [31:0]
  output logic [31:0]     m_axis_tdata,
  // lines_parallel [0], degenerate [1]
  output logic [1:0]      m_axis_tuser
);

  localparam logic [31:0] LIMIT_RESET = 32'd42950;

  logic [31:0] parallel_limit;
  root_item_t  front_item;
  root_item_t  root_item;
  logic        front_valid;
  logic        front_ready;

  // threshold; user must write it only with the pipeline empty; not enforced
  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      parallel_limit <= cfg_data;
    end
  end

  lld_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .parallel_limit(parallel_limit),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_data       (s_axis_tdata),
    .out_valid     (front_valid),
    .out_ready     (front_ready),
    .out_item      (front_item)
  );

  lld_root u_root (
    .clk      (clk),
    .rst      (rst),
    .in_valid (front_valid),
    .in_ready (front_ready),
    .in_item  (front_item),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_item (root_item)
  );

  // the last root stage is the output register
  assign m_axis_tdata = root_item.root;
  assign m_axis_tuser = {root_item.deg, root_item.par};

endmodule

FILE: sv/lld_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lld_front - vector arithmetic stages
// Forms the cross products, dot products and the square of the triple
// product, picks the skew or parallel branch and hands numerator and
// denominator to the root chain.
// ----------------------------------------------------------------------------
module lld_front
  import lld_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      parallel_limit,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IN_W-1:0]  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output root_item_t       out_item
);

  localparam int NST = 12;
  localparam int THR_SHIFT = 4 * FRAC_BITS - 32;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 0: point difference and directions
  logic signed [32:0] dp0 [3];
  logic signed [31:0] d10 [3];
  logic signed [31:0] d20 [3];
  logic [31:0]        fld [NUM_IN];

  always_comb begin
    for (int i = 0; i < NUM_IN; i++) begin
      fld[i] = in_data[i*COORD_W +: COORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        dp0[i] <= $signed({fld[6+i][31], fld[6+i]}) - $signed({fld[i][31], fld[i]});
        d10[i] <= $signed(fld[3+i]);
        d20[i] <= $signed(fld[9+i]);
      end
    end
  end

  // stage 1: coordinate products
  logic signed [63:0] mn1 [6];
  logic signed [64:0] ma1 [6];
  logic signed [63:0] sq1 [3];
  logic signed [32:0] dp1 [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mn1[0] <= d10[1] * d20[2];
      mn1[1] <= d10[2] * d20[1];
      mn1[2] <= d10[2] * d20[0];
      mn1[3] <= d10[0] * d20[2];
      mn1[4] <= d10[0] * d20[1];
      mn1[5] <= d10[1] * d20[0];
      ma1[0] <= dp0[1] * d10[2];
      ma1[1] <= dp0[2] * d10[1];
      ma1[2] <= dp0[2] * d10[0];
      ma1[3] <= dp0[0] * d10[2];
      ma1[4] <= dp0[0] * d10[1];
      ma1[5] <= dp0[1] * d10[0];
      for (int i = 0; i < 3; i++) begin
        sq1[i] <= d10[i] * d10[i];
        dp1[i] <= dp0[i];
      end
    end
  end

  // stage 2: cross products and |d1|^2
  logic signed [64:0] n2 [3];
  logic signed [65:0] a2 [3];
  logic [63:0]        v2;
  logic signed [32:0] dp2 [3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        n2[i]  <= {mn1[2*i][63], mn1[2*i]} - {mn1[2*i+1][63], mn1[2*i+1]};
        a2[i]  <= {ma1[2*i][64], ma1[2*i]} - {ma1[2*i+1][64], ma1[2*i+1]};
        dp2[i] <= dp1[i];
      end
      v2 <= {1'b0, sq1[0][62:0]} + {1'b0, sq1[1][62:0]} + {1'b0, sq1[2][62:0]};
    end
  end

  // stage 3: magnitudes and signs
  logic [63:0] nm3 [3];
  logic [64:0] am3 [3];
  logic [32:0] dpm3 [3];
  logic        sg3 [3];
  logic [63:0] v3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        nm3[i]  <= n2[i][64] ? 64'(-n2[i]) : n2[i][63:0];
        am3[i]  <= a2[i][65] ? 65'(-a2[i]) : a2[i][64:0];
        dpm3[i] <= dp2[i][32] ? 33'(-dp2[i]) : dp2[i];
        sg3[i]  <= dp2[i][32] ^ n2[i][64];
      end
      v3 <= v2;
    end
  end

  // stage 4: partial products of the wide squares and the triple product
  logic [63:0] qhh4 [3];
  logic [63:0] qll4 [3];
  logic [63:0] qhl4 [3];
  logic [65:0] ahh4 [3];
  logic [63:0] all4 [3];
  logic [64:0] ahl4 [3];
  logic [64:0] sph4 [3];
  logic [64:0] spl4 [3];
  logic        sg4 [3];
  logic [63:0] v4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        qhh4[i] <= nm3[i][63:32] * nm3[i][63:32];
        qll4[i] <= nm3[i][31:0] * nm3[i][31:0];
        qhl4[i] <= nm3[i][63:32] * nm3[i][31:0];
        ahh4[i] <= am3[i][64:32] * am3[i][64:32];
        all4[i] <= am3[i][31:0] * am3[i][31:0];
        ahl4[i] <= am3[i][64:32] * am3[i][31:0];
        sph4[i] <= dpm3[i] * nm3[i][63:32];
        spl4[i] <= dpm3[i] * nm3[i][31:0];
        sg4[i]  <= sg3[i];
      end
      v4 <= v3;
    end
  end

  // stage 5: recombine partial products
  logic [127:0] nsq5 [3];
  logic [129:0] asq5 [3];
  logic [96:0]  sp5 [3];
  logic         sg5 [3];
  logic [63:0]  v5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < 3; i++) begin
        nsq5[i] <= {qhh4[i], qll4[i]} + 128'({qhl4[i], 33'b0});
        asq5[i] <= {ahh4[i], all4[i]} + 130'({ahl4[i], 33'b0});
        sp5[i]  <= {sph4[i], 32'b0} + 97'(spl4[i]);
        sg5[i]  <= sg4[i];
      end
      v5 <= v4;
    end
  end

  // stage 6: sum the squares, apply the term signs
  logic [127:0]       q6;
  logic [129:0]       aa6;
  logic signed [97:0] st6 [3];
  logic [63:0]        v6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      q6  <= nsq5[0] + nsq5[1] + nsq5[2];
      aa6 <= asq5[0] + asq5[1] + asq5[2];
      for (int i = 0; i < 3; i++) begin
        st6[i] <= sg5[i] ? -{1'b0, sp5[i]} : {1'b0, sp5[i]};
      end
      v6 <= v5;
    end
  end

  // stage 7: triple product and the branch decision
  logic [DEN_W-1:0]    thr;
  logic signed [99:0]  s7;
  logic                skew7;
  logic                deg7;
  logic [127:0]        q7;
  logic [129:0]        aa7;
  logic [63:0]         v7;

  assign thr = DEN_W'(parallel_limit) << THR_SHIFT;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7    <= {{2{st6[0][97]}}, st6[0]} + {{2{st6[1][97]}}, st6[1]}
             + {{2{st6[2][97]}}, st6[2]};
      skew7 <= q6 > thr;
      deg7  <= (q6 <= thr) && (v6 == '0);
      q7    <= q6;
      aa7   <= aa6;
      v7    <= v6;
    end
  end

  // stage 8: magnitude of the triple product
  logic [98:0]  sm8;
  logic         skew8;
  logic         deg8;
  logic [127:0] q8;
  logic [129:0] aa8;
  logic [63:0]  v8;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      sm8   <= s7[99] ? 99'(-s7) : s7[98:0];
      skew8 <= skew7;
      deg8  <= deg7;
      q8    <= q7;
      aa8   <= aa7;
      v8    <= v7;
    end
  end

  // stage 9: partial products of the squared triple product
  logic [63:0]  p00, p11, p01;
  logic [69:0]  p22;
  logic [66:0]  p02, p12;
  logic         skew9;
  logic         deg9;
  logic [127:0] q9;
  logic [129:0] aa9;
  logic [63:0]  v9;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      p00   <= sm8[31:0] * sm8[31:0];
      p11   <= sm8[63:32] * sm8[63:32];
      p22   <= sm8[98:64] * sm8[98:64];
      p01   <= sm8[31:0] * sm8[63:32];
      p02   <= sm8[31:0] * sm8[98:64];
      p12   <= sm8[63:32] * sm8[98:64];
      skew9 <= skew8;
      deg9  <= deg8;
      q9    <= q8;
      aa9   <= aa8;
      v9    <= v8;
    end
  end

  // stage 10: gather the cross terms
  logic [REM_W-1:0] x10, y10;
  logic             skew10;
  logic             deg10;
  logic [127:0]     q10;
  logic [129:0]     aa10;
  logic [63:0]      v10;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      x10    <= REM_W'({p01, 1'b0}) + REM_W'({p02, 33'b0}) + REM_W'({p12, 65'b0});
      y10    <= {p22, p11, p00};
      skew10 <= skew9;
      deg10  <= deg9;
      q10    <= q9;
      aa10   <= aa9;
      v10    <= v9;
    end
  end

  // stage 11: finish the square, select the branch operands
  // a zero first direction gets numerator 0 over 1, so the root comes out 0
  always_ff @(posedge clk) begin
    if (en[11]) begin
      if (deg10) begin
        out_item.rem <= '0;
        out_item.den <= DEN_W'(1);
      end else if (skew10) begin
        out_item.rem <= y10 + {x10[REM_W-33:0], 32'b0};
        out_item.den <= q10;
      end else begin
        out_item.rem <= REM_W'(aa10);
        out_item.den <= DEN_W'(v10);
      end
      out_item.prod <= '0;
      out_item.root <= '0;
      out_item.par  <= !skew10;
      out_item.deg  <= deg10;
    end
  end

endmodule

FILE: sv/lld_root_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lld_root_step - one result bit of floor(sqrt(rem / den))
// First stage forms the trial term and the advanced product, second stage
// compares and commits the bit.
// ----------------------------------------------------------------------------
module lld_root_step
  import lld_pkg::*;
#(
  parameter int BIT = 31
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  root_item_t in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output root_item_t out_item
);

  logic             va, vb;
  logic             ena, enb;
  root_item_t       ia;
  root_item_t       item_next;
  logic [REM_W-1:0] ta;
  logic [PROD_W-1:0] pa;

  assign enb       = !vb || out_ready;
  assign ena       = !va || enb;
  assign in_ready  = ena;
  assign out_valid = vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (ena) begin
        va <= in_valid;
      end
      if (enb) begin
        vb <= va;
      end
    end
  end

  // trial term (2*root*2^BIT + 2^(2*BIT)) * den
  always_ff @(posedge clk) begin
    if (ena) begin
      ia <= in_item;
      ta <= (REM_W'(in_item.prod) << (BIT + 1)) + (REM_W'(in_item.den) << (2 * BIT));
      pa <= in_item.prod + (PROD_W'(in_item.den) << BIT);
    end
  end

  // commit the bit when the trial term fits in the remainder
  always_comb begin
    item_next = ia;
    if (ta <= ia.rem) begin
      item_next.rem  = ia.rem - ta;
      item_next.prod = pa;
      item_next.root = ia.root | (ROOT_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (enb) begin
      out_item <= item_next;
    end
  end

endmodule

FILE: sv/lld_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lld_root - pipelined ratio square root
// Chain of one step per result bit, most significant first.
// ----------------------------------------------------------------------------
module lld_root
  import lld_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  root_item_t in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output root_item_t out_item
);

  root_item_t item [ROOT_W+1];
  logic       vl   [ROOT_W+1];
  logic       rd   [ROOT_W+1];

  assign item[0]    = in_item;
  assign vl[0]      = in_valid;
  assign in_ready   = rd[0];
  assign out_item   = item[ROOT_W];
  assign out_valid  = vl[ROOT_W];
  assign rd[ROOT_W] = out_ready;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    lld_root_step #(
      .BIT(ROOT_W - 1 - k)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .in_valid (vl[k]),
      .in_ready (rd[k]),
      .in_item  (item[k]),
      .out_valid(vl[k+1]),
      .out_ready(rd[k+1]),
      .out_item (item[k+1])
    );
  end

endmodule
